>>> sv/rtps_pkg.sv
// Shared constants, widths and the arctangent table of the right-triangle polar solver.
package rtps_pkg;

    // Default configuration of the core.
    localparam int LEG_WIDTH_DEF       = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    // Longest rotation chain that the arctangent table supports.
    localparam int MAX_STAGES = 32;

    // Fraction bits added below each leg before the rotations start.
    localparam int GUARD_BITS = 24;

    // The angle accumulator counts 1/65536 degree; results are in 1/256 degree.
    localparam int Z_W    = 25;
    localparam int Z_DROP = 8;

    // Result angles and the right angle in output units.
    localparam int             ANGLE_W     = 15;
    localparam logic [ANGLE_W-1:0] RIGHT_ANGLE = 15'd23040;

    // round(atan(2^-i) * 180/pi * 65536) for each rotation i.
    localparam int ATAN_STEPS [0:MAX_STAGES-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

endpackage

>>> sv/rtps_in_if.sv
// Input channel of the polar solver: the two legs of one right triangle.
interface rtps_in_if #(
    parameter int LEG_WIDTH = rtps_pkg::LEG_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [LEG_WIDTH-1:0] side_x;
    logic [LEG_WIDTH-1:0] side_y;

    modport source (output valid, output side_x, output side_y, input ready);
    modport sink   (input valid, input side_x, input side_y, output ready);
endinterface

>>> sv/rtps_out_if.sv
// Output channel of the polar solver: hypotenuse, both angles and the degenerate flag.
interface rtps_out_if #(
    parameter int LEG_WIDTH = rtps_pkg::LEG_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [LEG_WIDTH:0]           hypotenuse;
    logic [rtps_pkg::ANGLE_W-1:0] angle_a;
    logic [rtps_pkg::ANGLE_W-1:0] angle_b;
    logic                         degenerate;

    modport source (output valid, output hypotenuse, output angle_a, output angle_b,
                    output degenerate, input ready);
    modport sink   (input valid, input hypotenuse, input angle_a, input angle_b,
                    input degenerate, output ready);
endinterface

>>> sv/right_triangle_polar_solver_core.sv
// Top level of the right-triangle polar solver: squaring, root and rotation pipeline.
//
//  channel  | role | payload                                         | handshake
//  ---------+------+-------------------------------------------------+-------------
//  legs     | sink | side_x, side_y (LEG_WIDTH bits each)             | valid/ready
//  result   | src  | hypotenuse, angle_a, angle_b, degenerate          | valid/ready
//
// One transfer is accepted every cycle unless a waiting result holds the pipeline. It has
// one squaring stage, one summing stage, one stage per root bit and per rotation (both
// chains run side by side), and the output register.
// rst_n clears every valid bit asynchronously; the data registers hold no reset.
// When a result waits at the output and result.ready is low, the whole pipeline holds,
// so no transfer is lost or repeated; empty slots are filled again as soon as it moves.
module right_triangle_polar_solver_core #(
    parameter int LEG_WIDTH       = rtps_pkg::LEG_WIDTH_DEF,
    parameter int ROTATION_STAGES = rtps_pkg::ROTATION_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rtps_in_if.sink     legs,
    rtps_out_if.source  result
);

    // Root datapath: LEG_WIDTH+1 result bits, one bit pair of the radicand per stage.
    localparam int SQ_W     = LEG_WIDTH + 1;
    localparam int SQ_STEPS = SQ_W;
    localparam int REM_W    = LEG_WIDTH + 3;
    localparam int RAD_W    = 2 * SQ_W;

    // Rotation datapath: guard bits below the leg, and headroom for the CORDIC gain
    // plus the sign.
    localparam int CW = LEG_WIDTH + rtps_pkg::GUARD_BITS + 3;
    localparam int NR = (ROTATION_STAGES > rtps_pkg::MAX_STAGES) ?
                        rtps_pkg::MAX_STAGES : ROTATION_STAGES;

    localparam int DEPTH = (SQ_STEPS > NR) ? SQ_STEPS : NR;

    localparam int Z_W     = rtps_pkg::Z_W;
    localparam int Q_W     = Z_W - rtps_pkg::Z_DROP;
    localparam int ANGLE_W = rtps_pkg::ANGLE_W;
    localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1 << (rtps_pkg::Z_DROP - 1));

    // The pipeline moves whenever the output register is empty or being drained.
    logic advance;

    // Squaring stage.
    logic                   mul_vld_reg;
    logic [2*LEG_WIDTH-1:0] xx_reg, yy_reg;
    logic [LEG_WIDTH-1:0]   x_reg, y_reg;
    logic [LEG_WIDTH-1:0]   x_in, y_in;
    logic [2*LEG_WIDTH-1:0] xx_next, yy_next;

    // Iteration stages; index 0 is the summing stage, index DEPTH the last iteration.
    logic                    vld_reg  [0:DEPTH];
    logic                    xz_reg   [0:DEPTH];
    logic                    yz_reg   [0:DEPTH];
    logic [RAD_W-1:0]        rad_reg  [0:DEPTH];
    logic [SQ_W-1:0]         root_reg [0:DEPTH];
    logic [REM_W-1:0]        rem_reg  [0:DEPTH];
    logic signed [CW-1:0]    cx_reg   [0:DEPTH];
    logic signed [CW-1:0]    cy_reg   [0:DEPTH];
    logic signed [Z_W-1:0]   z_reg    [0:DEPTH];

    logic [RAD_W-1:0]        rad_next  [1:DEPTH];
    logic [SQ_W-1:0]         root_next [1:DEPTH];
    logic [REM_W-1:0]        rem_next  [1:DEPTH];
    logic signed [CW-1:0]    cx_next   [1:DEPTH];
    logic signed [CW-1:0]    cy_next   [1:DEPTH];
    logic signed [Z_W-1:0]   z_next    [1:DEPTH];

    // Output register.
    logic                 out_vld_reg;
    logic [SQ_W-1:0]      hyp_reg, hyp_next;
    logic [ANGLE_W-1:0]   ang_a_reg, ang_a_next;
    logic [ANGLE_W-1:0]   ang_b_reg, ang_b_next;
    logic                 deg_reg, deg_next;

    assign advance    = !out_vld_reg || result.ready;
    assign legs.ready = advance;

    assign x_in    = LEG_WIDTH'(legs.side_x);
    assign y_in    = LEG_WIDTH'(legs.side_y);
    assign xx_next = x_in * x_in;
    assign yy_next = y_in * y_in;

    // Each stage reads only its own registers, so the stages below are independent.
    // A stage past the end of a chain just passes that chain's values along.
    always_comb
    begin
        logic [REM_W-1:0]      rem_sh;
        logic [REM_W-1:0]      trial;
        logic signed [CW-1:0]  dx;
        logic signed [CW-1:0]  dy;
        logic signed [Z_W-1:0] step;
        rem_sh = '0;
        trial  = '0;
        dx     = '0;
        dy     = '0;
        step   = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rad_next[k+1]  = rad_reg[k];
            root_next[k+1] = root_reg[k];
            rem_next[k+1]  = rem_reg[k];
            cx_next[k+1]   = cx_reg[k];
            cy_next[k+1]   = cy_reg[k];
            z_next[k+1]    = z_reg[k];

            // Restoring square root, one result bit per stage.
            if (k < SQ_STEPS)
            begin
                rem_sh = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
                trial  = {root_reg[k], 2'b01};
                rad_next[k+1] = rad_reg[k] << 2;
                if (rem_sh >= trial)
                begin
                    rem_next[k+1]  = rem_sh - trial;
                    root_next[k+1] = {root_reg[k][SQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k+1]  = rem_sh;
                    root_next[k+1] = {root_reg[k][SQ_W-2:0], 1'b0};
                end
            end

            // Vectoring rotation: drive y toward zero and collect the angle.
            if (k < NR)
            begin
                dx   = cy_reg[k] >>> k;
                dy   = cx_reg[k] >>> k;
                step = Z_W'(rtps_pkg::ATAN_STEPS[k]);
                if (cy_reg[k] > 0)
                begin
                    cx_next[k+1] = cx_reg[k] + dx;
                    cy_next[k+1] = cy_reg[k] - dy;
                    z_next[k+1]  = z_reg[k] + step;
                end
                else
                begin
                    cx_next[k+1] = cx_reg[k] - dx;
                    cy_next[k+1] = cy_reg[k] + dy;
                    z_next[k+1]  = z_reg[k] - step;
                end
            end
        end
    end

    // Output stage: round the root, bring the angle to 1/256 degree and apply the
    // special cases of a zero leg.
    always_comb
    begin
        logic signed [Z_W-1:0] z_pos;
        logic signed [Z_W-1:0] z_rnd;
        logic [Q_W-1:0]        q;
        logic [ANGLE_W-1:0]    ang;
        z_pos = (z_reg[DEPTH] < 0) ? '0 : z_reg[DEPTH];
        z_rnd = z_pos + Z_ROUND;
        q     = z_rnd[Z_W-1:rtps_pkg::Z_DROP];
        if (q > Q_W'(rtps_pkg::RIGHT_ANGLE))
        begin
            ang = rtps_pkg::RIGHT_ANGLE;
        end
        else
        begin
            ang = q[ANGLE_W-1:0];
        end
        if (xz_reg[DEPTH])
        begin
            ang = rtps_pkg::RIGHT_ANGLE;
        end
        else if (yz_reg[DEPTH])
        begin
            ang = '0;
        end

        hyp_next = (rem_reg[DEPTH] > REM_W'(root_reg[DEPTH])) ?
                   root_reg[DEPTH] + SQ_W'(1) : root_reg[DEPTH];
        deg_next = xz_reg[DEPTH] && yz_reg[DEPTH];
        if (deg_next)
        begin
            hyp_next   = '0;
            ang_a_next = '0;
            ang_b_next = '0;
        end
        else
        begin
            ang_a_next = ang;
            ang_b_next = rtps_pkg::RIGHT_ANGLE - ang;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            mul_vld_reg <= legs.valid;
            vld_reg[0]  <= mul_vld_reg;
            for (int k = 1; k <= DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[DEPTH];
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            x_reg  <= x_in;
            y_reg  <= y_in;

            xz_reg[0]   <= (x_reg == '0);
            yz_reg[0]   <= (y_reg == '0);
            rad_reg[0]  <= RAD_W'(xx_reg) + RAD_W'(yy_reg);
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            cx_reg[0]   <= signed'(CW'(x_reg) << rtps_pkg::GUARD_BITS);
            cy_reg[0]   <= signed'(CW'(y_reg) << rtps_pkg::GUARD_BITS);
            z_reg[0]    <= '0;

            for (int k = 1; k <= DEPTH; k++)
            begin
                xz_reg[k]   <= xz_reg[k-1];
                yz_reg[k]   <= yz_reg[k-1];
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                cx_reg[k]   <= cx_next[k];
                cy_reg[k]   <= cy_next[k];
                z_reg[k]    <= z_next[k];
            end

            hyp_reg   <= hyp_next;
            ang_a_reg <= ang_a_next;
            ang_b_reg <= ang_b_next;
            deg_reg   <= deg_next;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.hypotenuse = hyp_reg;
    assign result.angle_a    = ang_a_reg;
    assign result.angle_b    = ang_b_reg;
    assign result.degenerate = deg_reg;

    // A degenerate triangle reports all zeros.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && deg_reg |-> hyp_reg == '0 && ang_a_reg == '0 && ang_b_reg == '0)
        else $error("degenerate result carries nonzero fields");

    // The two angles of a real triangle add up to a right angle.
    a_angle_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !deg_reg |->
            (ANGLE_W+1)'(ang_a_reg) + (ANGLE_W+1)'(ang_b_reg) ==
            (ANGLE_W+1)'(rtps_pkg::RIGHT_ANGLE))
        else $error("angle_a and angle_b do not add up to ninety degrees");

    // Saturation keeps angle a within a right angle.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ang_a_reg <= rtps_pkg::RIGHT_ANGLE)
        else $error("angle_a beyond ninety degrees");

    // A new result only appears after the last iteration stage held an item.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !$past(out_vld_reg) |-> $past(vld_reg[DEPTH]))
        else $error("result appeared without an item in the last stage");

endmodule

>>> bench/rtps_polar_checker.sv
// Checker for the polar solver: predicts each result from the accepted legs and compares it.
module rtps_polar_checker #(
    parameter int LEG_WIDTH       = rtps_pkg::LEG_WIDTH_DEF,
    parameter int ROTATION_STAGES = rtps_pkg::ROTATION_STAGES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rtps_in_if   legs,
    rtps_out_if  result,
    output int   failures,
    output int   outstanding,
    output int   results_checked,
    output int   degenerate_seen
);

    localparam int TABLE_DEPTH = 32;

    // Rotation angles in 1/65536 degree: round(atan(2^-i) * 180/pi * 65536).
    localparam longint ROTATION_ANGLE [0:TABLE_DEPTH-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic [LEG_WIDTH-1:0]         side_x;
        logic [LEG_WIDTH-1:0]         side_y;
        logic [LEG_WIDTH:0]           hypotenuse;
        logic [rtps_pkg::ANGLE_W-1:0] angle_a;
        logic [rtps_pkg::ANGLE_W-1:0] angle_b;
        logic                         degenerate;
    } polar_solution_t;

    polar_solution_t expected_polar [$];
    int mismatch_count;
    int queued_count;
    int checked_count;
    int degenerate_count;

    assign failures        = mismatch_count;
    assign outstanding     = queued_count;
    assign results_checked = checked_count;
    assign degenerate_seen = degenerate_count;

    initial
    begin
        mismatch_count   = 0;
        queued_count     = 0;
        checked_count    = 0;
        degenerate_count = 0;
    end

    // Rounded integer square root of x*x + y*y, one result bit per step.
    function automatic logic [LEG_WIDTH:0] rounded_hypotenuse(logic [LEG_WIDTH-1:0] x,
                                                             logic [LEG_WIDTH-1:0] y);
        logic [2*LEG_WIDTH+1:0] sum_sq;
        longint unsigned        root;
        longint unsigned        rem;
        longint unsigned        trial;
        sum_sq = (2*LEG_WIDTH+2)'(x) * (2*LEG_WIDTH+2)'(x)
               + (2*LEG_WIDTH+2)'(y) * (2*LEG_WIDTH+2)'(y);
        root = 0;
        rem  = 0;
        for (int p = LEG_WIDTH; p >= 0; p--)
        begin
            rem   = (rem << 2) | 64'(sum_sq[2*p +: 2]);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        if (rem > root)
            root = root + 1;
        return root[LEG_WIDTH:0];
    endfunction

    // Vectoring rotations drive y toward zero; the accumulated angle is atan(y/x).
    function automatic logic [rtps_pkg::ANGLE_W-1:0] vector_angle(logic [LEG_WIDTH-1:0] x,
                                                                 logic [LEG_WIDTH-1:0] y);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint z;
        longint q;
        int     n;
        cx = longint'(x) <<< rtps_pkg::GUARD_BITS;
        cy = longint'(y) <<< rtps_pkg::GUARD_BITS;
        z  = 0;
        n  = (ROTATION_STAGES > TABLE_DEPTH) ? TABLE_DEPTH : ROTATION_STAGES;
        for (int i = 0; i < n; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ROTATION_ANGLE[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ROTATION_ANGLE[i];
            end
        end
        if (z < 0)
            z = 0;
        q = (z + 128) >>> rtps_pkg::Z_DROP;
        if (q > longint'(rtps_pkg::RIGHT_ANGLE))
            q = longint'(rtps_pkg::RIGHT_ANGLE);
        return q[rtps_pkg::ANGLE_W-1:0];
    endfunction

    function automatic polar_solution_t solve_triangle(logic [LEG_WIDTH-1:0] x,
                                                      logic [LEG_WIDTH-1:0] y);
        polar_solution_t s;
        s.side_x     = x;
        s.side_y     = y;
        s.hypotenuse = '0;
        s.angle_a    = '0;
        s.angle_b    = '0;
        s.degenerate = 1'b0;
        if (x == 0 && y == 0)
        begin
            s.degenerate = 1'b1;
        end
        else
        begin
            s.hypotenuse = rounded_hypotenuse(x, y);
            if (x == 0)
                s.angle_a = rtps_pkg::RIGHT_ANGLE;
            else if (y == 0)
                s.angle_a = '0;
            else
                s.angle_a = vector_angle(x, y);
            s.angle_b = rtps_pkg::RIGHT_ANGLE - s.angle_a;
        end
        return s;
    endfunction

    task automatic compare_field(string field, longint unsigned want, longint unsigned got,
                                 polar_solution_t s);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch for legs (%0d, %0d): expected %0d, got %0d",
                     $time, field, s.side_x, s.side_y, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_channels
        polar_solution_t want;
        if (rst_n)
        begin
            if (legs.valid && legs.ready)
            begin
                expected_polar.push_back(solve_triangle(legs.side_x, legs.side_y));
                queued_count++;
            end
            if (result.valid && result.ready)
            begin
                if (expected_polar.size() == 0)
                begin
                    mismatch_count++;
                    $display({"%0t: result with nothing pending: expected none, ",
                              "got hyp %0d a %0d b %0d deg %0b"},
                             $time, result.hypotenuse, result.angle_a, result.angle_b,
                             result.degenerate);
                end
                else
                begin
                    want = expected_polar.pop_front();
                    queued_count--;
                    checked_count++;
                    if (result.degenerate)
                        degenerate_count++;
                    compare_field("hypotenuse", 64'(want.hypotenuse),
                                  64'(result.hypotenuse), want);
                    compare_field("angle_a", 64'(want.angle_a), 64'(result.angle_a), want);
                    compare_field("angle_b", 64'(want.angle_b), 64'(result.angle_b), want);
                    compare_field("degenerate", 64'(want.degenerate),
                                  64'(result.degenerate), want);
                end
            end
        end
    end

endmodule

>>> bench/right_triangle_polar_solver_core_test.sv
// Top of the polar solver testbench: clock, reset, leg stimulus, result back-pressure and verdict.
module right_triangle_polar_solver_core_test;

    localparam int LEG_WIDTH       = rtps_pkg::LEG_WIDTH_DEF;
    localparam int ROTATION_STAGES = rtps_pkg::ROTATION_STAGES_DEF;

    // Fill time of the pipeline, from the stage depth of the core.
    localparam int PIPE_LATENCY = ((LEG_WIDTH + 1 > ROTATION_STAGES) ?
                                   LEG_WIDTH + 1 : ROTATION_STAGES) + 3;

    // Number of random leg pairs after the directed ones.
    localparam int RANDOM_PAIRS = 950;

    // Cycles without any transfer on either channel before the run is declared hung.
    // The longest legal quiet stretch is a long source gap or sink stall plus the
    // pipeline fill, so this leaves a wide margin.
    localparam int STALL_LIMIT = 4000;

    localparam logic [LEG_WIDTH-1:0] LEG_MAX = '1;

    logic clk;
    logic rst_n;

    rtps_in_if  #(.LEG_WIDTH(LEG_WIDTH)) legs_ch ();
    rtps_out_if #(.LEG_WIDTH(LEG_WIDTH)) result_ch ();

    right_triangle_polar_solver_core #(
        .LEG_WIDTH       (LEG_WIDTH),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .legs   (legs_ch),
        .result (result_ch)
    );

    int failures;
    int outstanding;
    int results_checked;
    int degenerate_seen;

    rtps_polar_checker #(
        .LEG_WIDTH       (LEG_WIDTH),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .legs            (legs_ch),
        .result          (result_ch),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .degenerate_seen (degenerate_seen)
    );

    // While calm is set, neither side inserts gaps, so the pipeline runs at full rate.
    bit calm;
    int pairs_sent;
    int directed_pairs;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offers one leg pair after a random gap and returns once it has been taken.
    // Inputs change on the falling edge; the handshake is judged on the rising edge,
    // where the values seen are the ones the core sampled.
    task automatic send_legs(logic [LEG_WIDTH-1:0] x, logic [LEG_WIDTH-1:0] y);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            legs_ch.valid  <= 1'b0;
            legs_ch.side_x <= LEG_WIDTH'($urandom);
            legs_ch.side_y <= LEG_WIDTH'($urandom);
            repeat (gap) @(negedge clk);
        end
        legs_ch.valid  <= 1'b1;
        legs_ch.side_x <= x;
        legs_ch.side_y <= y;
        @(posedge clk);
        while (!legs_ch.ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Random legs, weighted toward the shapes where the angle and root logic is stressed:
    // tiny triangles, one leg zero, nearly isosceles, very flat or very steep ratios,
    // powers of two and legs close to full scale.
    task automatic send_random_legs();
        int                   kind;
        int                   delta;
        logic [LEG_WIDTH-1:0] x;
        logic [LEG_WIDTH-1:0] y;
        logic [LEG_WIDTH-1:0] t;
        kind = $urandom_range(0, 99);
        x = LEG_WIDTH'($urandom);
        y = LEG_WIDTH'($urandom);
        if (kind < 35)
        begin
            // Uniform over the whole field.
        end
        else if (kind < 50)
        begin
            x = LEG_WIDTH'($urandom_range(0, 15));
            y = LEG_WIDTH'($urandom_range(0, 15));
        end
        else if (kind < 58)
        begin
            if ($urandom_range(0, 1))
                x = '0;
            else
                y = '0;
        end
        else if (kind < 68)
        begin
            delta = $urandom_range(0, 6) - 3;
            y = LEG_WIDTH'(int'(x) + delta);
        end
        else if (kind < 78)
        begin
            x = LEG_WIDTH'(1) << $urandom_range(0, LEG_WIDTH - 1);
            if ($urandom_range(0, 1))
                y = LEG_WIDTH'(1) << $urandom_range(0, LEG_WIDTH - 1);
        end
        else if (kind < 90)
        begin
            y = LEG_WIDTH'($urandom_range(1, 3));
        end
        else
        begin
            x = LEG_MAX - LEG_WIDTH'($urandom_range(0, 31));
            y = LEG_MAX - LEG_WIDTH'($urandom_range(0, 31));
        end
        // Swap half the time so both legs see every shape.
        if ($urandom_range(0, 1))
        begin
            t = x;
            x = y;
            y = t;
        end
        send_legs(x, y);
    endtask

    // Result side: bursts of ready, broken by stalls of random length.
    initial
    begin : result_backpressure
        int burst;
        int hold;
        result_ch.ready = 1'b0;
        forever
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            hold = pick_gap();
            repeat (hold)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
        end
    end

    // Watchdog: any cycle with a transfer on either channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((legs_ch.valid && legs_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results still pending",
                         $time, quiet, outstanding);
                $display("right_triangle_polar_solver_core_test: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        calm           = 1'b0;
        pairs_sent     = 0;
        directed_pairs = 0;

        rst_n          = 1'b0;
        legs_ch.valid  = 1'b0;
        legs_ch.side_x = '0;
        legs_ch.side_y = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs: both legs zero (degenerate), one leg zero at either end of
        // the range (exact right angle and flat angle), full scale on both legs,
        // unit legs, Pythagorean triples, alternating bit patterns and the half-scale
        // corner around 45 degrees.
        send_legs('0, '0);
        send_legs('0, LEG_WIDTH'(1));
        send_legs(LEG_WIDTH'(1), '0);
        send_legs('0, LEG_MAX);
        send_legs(LEG_MAX, '0);
        send_legs(LEG_MAX, LEG_MAX);
        send_legs(LEG_WIDTH'(1), LEG_WIDTH'(1));
        send_legs(LEG_WIDTH'(1), LEG_MAX);
        send_legs(LEG_MAX, LEG_WIDTH'(1));
        send_legs(LEG_WIDTH'(3), LEG_WIDTH'(4));
        send_legs(LEG_WIDTH'(5), LEG_WIDTH'(12));
        send_legs(LEG_WIDTH'(1), LEG_WIDTH'(2));
        send_legs(LEG_WIDTH'(2), LEG_WIDTH'(1));
        send_legs(16'h5555, 16'hAAAA);
        send_legs(16'hAAAA, 16'h5555);
        send_legs(16'h8000, 16'h8000);
        send_legs(16'h8000, 16'h7FFF);
        send_legs(16'h7FFF, 16'h8000);
        send_legs(LEG_WIDTH'(46341), LEG_WIDTH'(46341));
        send_legs('0, '0);
        directed_pairs = pairs_sent;

        // Random part in chunks; every fourth chunk runs without gaps on either side.
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            calm = ((i / 120) % 4) == 3;
            send_random_legs();
        end
        calm = 1'b0;

        @(negedge clk);
        legs_ch.valid <= 1'b0;

        // Drain: the watchdog catches a result that never arrives.
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Sent %0d leg pairs (%0d directed, rest random) under random gaps and stalls;",
                 pairs_sent, directed_pairs);
        $display("checked %0d results field by field, %0d of them degenerate, %0d mismatches.",
                 results_checked, degenerate_seen, failures);
        if (failures == 0)
            $display("right_triangle_polar_solver_core_test: clean");
        else
            $display("right_triangle_polar_solver_core_test: errors");
        $finish;
    end

endmodule
